[src/suv_pkg.sv]
// Shared constants, types and the back-end state encoding for sort_unique_values.
`default_nettype none
package suv_pkg;

   localparam int SET_SIZE    = 32;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 6;
   localparam int IDX_W       = $clog2(SET_SIZE);
   localparam int CNT_W       = $clog2(SET_SIZE + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      SUV_LOAD,
      SUV_SORT,
      SUV_COUNT,
      SUV_EMIT
   } suv_state_type;

   // One queued beat: the value and whether it completes the set.
   typedef struct packed {
      logic                      valid;
      logic                      last;
      logic signed [VALUE_W-1:0] value;
   } suv_beat_type;

endpackage
`default_nettype wire

[src/sort_unique_values.sv]
// Top level: sorts a set of signed Q16.16 values and emits the distinct ones in order.
//
//   channel   ports                                        handshake
//   request   req_sample_value                             start & !busy
//   response  rsp_distinct_value, rsp_is_final,            rsp_strobe, one cycle each
//             rsp_distinct_count
//
// A set of SET_SIZE beats loads into a row of cells via a 4-deep queue, one per cycle while the
// back end is in load and the queue holds a beat. Sorting runs alternating even and odd passes until
// two quiet passes in a row; a count walk and an emit walk then each step through all SET_SIZE cells.
// busy rises when the queue is full; it fills while the cell row is sorting, counting or emitting.
// Synchronous active-high reset empties the queue and returns the back end to load.
// Results cannot be held off: each response beat is valid for exactly one cycle.
`default_nettype none
module sort_unique_values (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic signed [suv_pkg::VALUE_W-1:0] req_sample_value,
   output logic                                    rsp_strobe,
   output logic signed [suv_pkg::VALUE_W-1:0]      rsp_distinct_value,
   output logic                                    rsp_is_final,
   output logic [suv_pkg::COUNT_W-1:0]             rsp_distinct_count
);

   suv_pkg::suv_beat_type head;
   logic pop;

   suv_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_sample_value (req_sample_value),
      .busy             (busy),
      .pop              (pop),
      .head             (head)
   );

   suv_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rsp_strobe         (rsp_strobe),
      .rsp_distinct_value (rsp_distinct_value),
      .rsp_is_final       (rsp_is_final),
      .rsp_distinct_count (rsp_distinct_count)
   );

endmodule
`default_nettype wire

[src/suv_front.sv]
// Front end: takes sample beats, tags the last beat of each set, queues them.
`default_nettype none
module suv_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [suv_pkg::VALUE_W-1:0] req_sample_value,
   output logic                                   busy,
   input  wire logic                              pop,
   output suv_pkg::suv_beat_type                  head
);

   logic signed [suv_pkg::VALUE_W-1:0] qvalue_ff [suv_pkg::QUEUE_DEPTH];
   logic                               qlast_ff  [suv_pkg::QUEUE_DEPTH];
   logic [suv_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [suv_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [suv_pkg::QCNT_W-1:0] qcount_ff, qcount_in;
   logic [suv_pkg::IDX_W-1:0]  load_ff, load_in;
   logic                       push;
   logic                       set_last;

   assign busy     = (qcount_ff == suv_pkg::QCNT_W'(suv_pkg::QUEUE_DEPTH));
   assign push     = start && !busy;
   assign set_last = (load_ff == suv_pkg::IDX_W'(suv_pkg::SET_SIZE - 1));

   assign head.valid = (qcount_ff != '0);
   assign head.last  = qlast_ff[rd_ptr_ff];
   assign head.value = qvalue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      qcount_in = qcount_ff;
      if (push && !pop) begin
         qcount_in = qcount_ff + 1'b1;
      end else if (!push && pop) begin
         qcount_in = qcount_ff - 1'b1;
      end
      load_in = load_ff;
      if (push) begin
         load_in = set_last ? '0 : load_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         qcount_ff <= '0;
         load_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         qcount_ff <= qcount_in;
         load_ff   <= load_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         qvalue_ff[wr_ptr_ff] <= req_sample_value;
         qlast_ff[wr_ptr_ff]  <= set_last;
      end
   end

   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      pop |-> qcount_ff != '0)
      else $error("queue popped while empty");
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      qcount_ff <= suv_pkg::QCNT_W'(suv_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_count_track : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> qcount_ff == $past(qcount_ff) + 1'b1)
      else $error("queue count missed a push");

endmodule
`default_nettype wire

[src/suv_back.sv]
// Back end: row of compare-exchange cells, sort passes, distinct count and emit walk.
`default_nettype none
module suv_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire suv_pkg::suv_beat_type              head,
   output logic                                    pop,
   output logic                                    rsp_strobe,
   output logic signed [suv_pkg::VALUE_W-1:0]      rsp_distinct_value,
   output logic                                    rsp_is_final,
   output logic [suv_pkg::COUNT_W-1:0]             rsp_distinct_count
);

   localparam int N = suv_pkg::SET_SIZE;

   suv_pkg::suv_state_type state_ff, state_in;
   logic signed [suv_pkg::VALUE_W-1:0] cell_ff [N];
   logic signed [suv_pkg::VALUE_W-1:0] cell_in [N];
   logic signed [suv_pkg::VALUE_W-1:0] prev_ff, prev_in;
   logic [suv_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [suv_pkg::CNT_W-1:0] count_ff, count_in;
   logic [suv_pkg::CNT_W-1:0] emitted_ff, emitted_in;
   logic phase_ff, phase_in;
   logic quiet_ff, quiet_in;
   logic swap;
   logic hit;
   logic idx_last;
   logic strobe_ff, strobe_in;
   logic final_ff, final_in;
   logic signed [suv_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [suv_pkg::COUNT_W-1:0] dcount_ff, dcount_in;

   assign idx_last = (idx_ff == suv_pkg::IDX_W'(N - 1));
   assign hit      = (idx_ff == '0) || (cell_ff[0] != prev_ff);

   always_comb begin
      state_in   = state_ff;
      cell_in    = cell_ff;
      prev_in    = prev_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      emitted_in = emitted_ff;
      phase_in   = phase_ff;
      quiet_in   = quiet_ff;
      swap       = 1'b0;
      pop        = 1'b0;
      strobe_in  = 1'b0;
      final_in   = final_ff;
      value_in   = value_ff;
      dcount_in  = dcount_ff;
      case (state_ff)
         suv_pkg::SUV_LOAD: begin
            if (head.valid) begin
               pop = 1'b1;
               for (int i = 0; i < N - 1; i++) begin
                  cell_in[i] = cell_ff[i+1];
               end
               cell_in[N-1] = head.value;
               if (head.last) begin
                  state_in = suv_pkg::SUV_SORT;
                  phase_in = 1'b0;
                  quiet_in = 1'b0;
               end
            end
         end
         suv_pkg::SUV_SORT: begin
            // even pass on pairs (0,1),(2,3)..., odd pass on (1,2),(3,4)...
            for (int i = 0; i < N - 1; i++) begin
               if ((i[0] == phase_ff) && (cell_ff[i] > cell_ff[i+1])) begin
                  cell_in[i]   = cell_ff[i+1];
                  cell_in[i+1] = cell_ff[i];
                  swap         = 1'b1;
               end
            end
            phase_in = !phase_ff;
            quiet_in = !swap;
            // two quiet passes in a row: every neighbour pair is in order
            if (!swap && quiet_ff) begin
               state_in = suv_pkg::SUV_COUNT;
               idx_in   = '0;
               count_in = suv_pkg::CNT_W'(1);
            end
         end
         suv_pkg::SUV_COUNT: begin
            for (int i = 0; i < N - 1; i++) begin
               cell_in[i] = cell_ff[i+1];
            end
            cell_in[N-1] = cell_ff[0];
            if (!idx_last && (cell_ff[0] != cell_ff[1])) begin
               count_in = count_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_last) begin
               state_in   = suv_pkg::SUV_EMIT;
               idx_in     = '0;
               emitted_in = '0;
            end
         end
         suv_pkg::SUV_EMIT: begin
            for (int i = 0; i < N - 1; i++) begin
               cell_in[i] = cell_ff[i+1];
            end
            cell_in[N-1] = cell_ff[0];
            prev_in = cell_ff[0];
            if (hit) begin
               strobe_in  = 1'b1;
               value_in   = cell_ff[0];
               final_in   = (suv_pkg::CNT_W'(emitted_ff + 1'b1) == count_ff);
               dcount_in  = suv_pkg::COUNT_W'(count_ff);
               emitted_in = emitted_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_last) begin
               state_in = suv_pkg::SUV_LOAD;
               idx_in   = '0;
            end
         end
         default: begin
            state_in = suv_pkg::SUV_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= suv_pkg::SUV_LOAD;
         idx_ff     <= '0;
         count_ff   <= '0;
         emitted_ff <= '0;
         phase_ff   <= 1'b0;
         quiet_ff   <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         count_ff   <= count_in;
         emitted_ff <= emitted_in;
         phase_ff   <= phase_in;
         quiet_ff   <= quiet_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff   <= cell_in;
      prev_ff   <= prev_in;
      final_ff  <= final_in;
      value_ff  <= value_in;
      dcount_ff <= dcount_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_distinct_value = value_ff;
   assign rsp_is_final       = final_ff;
   assign rsp_distinct_count = dcount_ff;

   a_strobe_from_emit : assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff) == suv_pkg::SUV_EMIT)
      else $error("result beat outside the emit walk");
   a_emit_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == suv_pkg::SUV_EMIT) |-> (emitted_ff <= count_ff && count_ff != '0))
      else $error("more distinct values emitted than counted");
   a_final_ends : assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && final_ff) |=> !strobe_ff)
      else $error("result beat after the final one");
   a_load_only : assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == suv_pkg::SUV_LOAD)
      else $error("queue popped outside load");

endmodule
`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for sort_unique_values: loads value sets, predicts the ordered distinct output.
`default_nettype none
module tb_top;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SET_LATENCY  = 4 * suv_pkg::SET_SIZE + 16;
   localparam int RANDOM_SETS  = 6;
   localparam int REPORT_LIMIT = 10;

   typedef enum int {
      FILL_RANDOM,
      FILL_ALL_SAME,
      FILL_FEW_VALUES,
      FILL_ALL_DISTINCT,
      FILL_EXTREMES
   } fill_kind_type;

   typedef struct {
      logic signed [suv_pkg::VALUE_W-1:0] value;
      logic                               final_flag;
      logic [suv_pkg::COUNT_W-1:0]        count;
   } distinct_beat_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic signed [suv_pkg::VALUE_W-1:0] req_sample_value = '0;
   logic                               rsp_strobe;
   logic signed [suv_pkg::VALUE_W-1:0] rsp_distinct_value;
   logic                               rsp_is_final;
   logic [suv_pkg::COUNT_W-1:0]        rsp_distinct_count;

   // predictor state: the partly loaded set
   logic signed [suv_pkg::VALUE_W-1:0] loaded_set [suv_pkg::SET_SIZE];
   int                                 fill_level = 0;
   distinct_beat_type                  pending_distinct [$];

   int  cycle_count    = 0;
   int  error_count    = 0;
   int  mismatch_count = 0;
   int  beats_checked  = 0;
   int  samples_sent   = 0;
   int  sets_sent      = 0;
   int  widest_run     = 0;
   int  narrowest_run  = suv_pkg::SET_SIZE + 1;
   bit  gapless        = 1'b0;

   sort_unique_values u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_sample_value   (req_sample_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_distinct_value (rsp_distinct_value),
      .rsp_is_final       (rsp_is_final),
      .rsp_distinct_count (rsp_distinct_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding",
                  cycle_count, pending_distinct.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Stores one sample; on the last sample of a set, sorts, collapses equal
   // neighbours and queues one expected beat per distinct value.
   task automatic absorb_sample(input logic signed [suv_pkg::VALUE_W-1:0] v);
      logic signed [suv_pkg::VALUE_W-1:0] sorted [suv_pkg::SET_SIZE];
      logic signed [suv_pkg::VALUE_W-1:0] hold;
      logic signed [suv_pkg::VALUE_W-1:0] uniq [$];
      distinct_beat_type                  b;
      int                                 i;
      int                                 j;
      loaded_set[fill_level] = v;
      fill_level++;
      if (fill_level < suv_pkg::SET_SIZE) return;
      fill_level = 0;
      sorted = loaded_set;
      for (i = 1; i < suv_pkg::SET_SIZE; i++) begin
         hold = sorted[i];
         j = i;
         while (j > 0 && sorted[j-1] > hold) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = hold;
      end
      for (i = 0; i < suv_pkg::SET_SIZE; i++) begin
         if (uniq.size() == 0 || uniq[uniq.size()-1] != sorted[i])
            uniq.push_back(sorted[i]);
      end
      for (i = 0; i < uniq.size(); i++) begin
         b.value      = uniq[i];
         b.final_flag = (i == uniq.size() - 1);
         b.count      = suv_pkg::COUNT_W'(uniq.size());
         pending_distinct.push_back(b);
      end
      if (uniq.size() > widest_run) widest_run = uniq.size();
      if (uniq.size() < narrowest_run) narrowest_run = uniq.size();
      sets_sent++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (gapless || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // start stays high across back-to-back beats; it only drops for a gap
   task automatic send_sample(input logic signed [suv_pkg::VALUE_W-1:0] v);
      int gap;
      start            <= 1'b1;
      req_sample_value <= v;
      do @(posedge clock); while (busy);
      absorb_sample(v);
      samples_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_distinct.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [suv_pkg::VALUE_W-1:0] edge_value();
      case ($urandom_range(0, 7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return 32'sh0000_0000;
         3:       return -32'sd1;
         4:       return 32'sh0000_0001;
         5:       return 32'sh8000_0001;
         6:       return 32'sh7FFF_FFFE;
         default: return 32'shFFFF_0000;
      endcase
   endfunction

   task automatic send_set(input fill_kind_type kind);
      logic signed [suv_pkg::VALUE_W-1:0] pool [3];
      logic [suv_pkg::VALUE_W-1:0]        base;
      logic [suv_pkg::VALUE_W-1:0]        stride;
      int                                 k;
      base   = $urandom();
      stride = $urandom() | 32'h1;
      for (k = 0; k < 3; k++) pool[k] = $urandom();
      for (k = 0; k < suv_pkg::SET_SIZE; k++) begin
         case (kind)
            FILL_ALL_SAME:     send_sample(base);
            FILL_FEW_VALUES:   send_sample(pool[$urandom_range(0, 2)]);
            // odd stride modulo 2^32 never repeats within one set
            FILL_ALL_DISTINCT: send_sample(base + stride * k);
            FILL_EXTREMES:     send_sample(edge_value());
            default:           send_sample($urandom());
         endcase
      end
   endtask

   // extremes, duplicates at both ends, sign boundary and Q16.16 unit steps
   task automatic test_boundary_set();
      logic signed [suv_pkg::VALUE_W-1:0] pattern [suv_pkg::SET_SIZE];
      int k;
      pattern = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF,
                  32'sh0000_0001, 32'sh8000_0001, 32'sh7FFF_FFFE, 32'sh0001_0000,
                  32'shFFFF_0000, 32'sh0000_8000, 32'shFFFF_8000, 32'sh5555_5555,
                  32'shAAAA_AAAA, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000,
                  32'sh0001_0000, 32'shFFFF_FFFF, 32'sh4000_0000, 32'shC000_0000,
                  32'sh0000_FFFF, 32'shFFFF_0001, 32'sh3333_3333, 32'shCCCC_CCCC,
                  32'sh0F0F_0F0F, 32'shF0F0_F0F0, 32'sh0001_0000, 32'sh8000_0000,
                  32'sh7FFF_FFFF, 32'sh0000_0002, 32'shFFFF_FFFE, 32'sh0000_0000};
      gapless = 1'b0;
      for (k = 0; k < suv_pkg::SET_SIZE; k++) send_sample(pattern[k]);
   endtask

   task automatic test_pause_between_sets();
      hold_until_drained();
   endtask

   // next set starts loading while the previous one is still sorting, so the
   // input queue fills and busy gets exercised
   task automatic test_back_to_back_sets();
      gapless = 1'b1;
      send_set(FILL_ALL_DISTINCT);
      send_set(FILL_ALL_SAME);
      gapless = 1'b0;
   endtask

   task automatic test_random_sets();
      fill_kind_type kind;
      int            s;
      for (s = 0; s < RANDOM_SETS; s++) begin
         case (s % 5)
            0:       kind = FILL_RANDOM;
            1:       kind = FILL_FEW_VALUES;
            2:       kind = FILL_ALL_DISTINCT;
            3:       kind = FILL_EXTREMES;
            default: kind = FILL_ALL_SAME;
         endcase
         if ($urandom_range(0, 2) == 0) kind = FILL_RANDOM;
         gapless = ($urandom_range(0, 3) == 0);
         send_set(kind);
         if ($urandom_range(0, 3) == 0) hold_until_drained();
      end
      gapless = 1'b0;
   endtask

   always @(posedge clock) begin
      distinct_beat_type want;
      if (!reset && rsp_strobe) begin
         if (pending_distinct.size() == 0) begin
            error_count++;
            $display("unexpected beat: value %h final %b count %0d",
                     rsp_distinct_value, rsp_is_final, rsp_distinct_count);
         end else begin
            want = pending_distinct.pop_front();
            beats_checked++;
            if (rsp_distinct_value !== want.value || rsp_is_final !== want.final_flag ||
                rsp_distinct_count !== want.count) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch on beat %0d: expected %h/%b/%0d got %h/%b/%0d",
                           beats_checked, want.value, want.final_flag, want.count,
                           rsp_distinct_value, rsp_is_final, rsp_distinct_count);
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_boundary_set();
      test_pause_between_sets();
      test_back_to_back_sets();
      test_random_sets();
      hold_until_drained();
      repeat (SET_LATENCY) @(posedge clock);
      if (pending_distinct.size() != 0) begin
         error_count++;
         $display("%0d expected beats never arrived", pending_distinct.size());
      end
      $display("%0d samples in %0d sets, %0d distinct-value beats checked",
               samples_sent, sets_sent, beats_checked);
      $display("distinct counts seen from %0d to %0d, %0d errors",
               narrowest_run, widest_run, error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
